>>> sv/ets_pkg.sv
package ets_pkg;

  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned MAX_TICKS   = 20;
  localparam int unsigned SPEED_W     = 10;
  localparam int unsigned PERIOD_W    = 10;
  localparam int unsigned TICKS_W     = 5;
  localparam int unsigned VIEW_W      = 2;
  localparam int unsigned STEP_W      = $clog2(TIME_BITS);

  localparam logic [SPEED_W-1:0]  SPEED_RESET   = SPEED_W'(100);
  localparam logic [PERIOD_W-1:0] EDITOR_PERIOD = PERIOD_W'(57);
  localparam logic [STEP_W-1:0]   LAST_STEP     = STEP_W'(TIME_BITS - 1);

  localparam logic [VIEW_W-1:0] VIEW_CITY   = 2'd1;
  localparam logic [VIEW_W-1:0] VIEW_EDITOR = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } sts_t;

  // Tick period in ms for a city view; zero means no ticks run.
  function automatic logic [PERIOD_W-1:0] city_period(input logic [SPEED_W-1:0] speed);
    logic [PERIOD_W-1:0] p;
    if (speed < SPEED_W'(10))       p = PERIOD_W'(0);
    else if (speed < SPEED_W'(20))  p = PERIOD_W'(502);
    else if (speed < SPEED_W'(30))  p = PERIOD_W'(352);
    else if (speed < SPEED_W'(40))  p = PERIOD_W'(242);
    else if (speed < SPEED_W'(50))  p = PERIOD_W'(162);
    else if (speed < SPEED_W'(60))  p = PERIOD_W'(112);
    else if (speed < SPEED_W'(70))  p = PERIOD_W'(82);
    else if (speed < SPEED_W'(80))  p = PERIOD_W'(57);
    else if (speed < SPEED_W'(90))  p = PERIOD_W'(37);
    else if (speed < SPEED_W'(100)) p = PERIOD_W'(22);
    else if (speed < SPEED_W'(101)) p = PERIOD_W'(16);
    else if (speed < SPEED_W'(200)) p = PERIOD_W'(16);
    else if (speed < SPEED_W'(300)) p = PERIOD_W'(8);
    else if (speed < SPEED_W'(400)) p = PERIOD_W'(5);
    else if (speed < SPEED_W'(500)) p = PERIOD_W'(3);
    else                            p = PERIOD_W'(2);
    return p;
  endfunction

endpackage

>>> sv/elapsed_tick_scheduler_core.sv
// Channel   Handshake                  Payload
// config    cfg_we_i                   cfg_wdata_i (speed setting)
// query     in_valid_i / in_ready_o    now_ms_i, paused_i, view_class_i,
//                                      construction_active_i, scroll_active_i,
//                                      scroll_smooth_i
// result    out_valid_o / out_ready_i  ticks_due_o
//
// A query that needs a division runs through the 32-step bit-serial divider between
// accept and result; any other query goes straight from accept to result.
// A new word can be accepted in the cycle after the previous result is loaded, not before.
// Reset sets the speed to 100 and clears the reference time and validity flag.
// A stalled result holds in the output register while the next query is computed.
module elapsed_tick_scheduler_core
  import ets_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SPEED_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_BITS-1:0] now_ms_i,
  input  logic                 paused_i,
  input  logic [VIEW_W-1:0]    view_class_i,
  input  logic                 construction_active_i,
  input  logic                 scroll_active_i,
  input  logic                 scroll_smooth_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TICKS_W-1:0]   ticks_due_o
);

  cmd_t cmd;
  sts_t sts;

  ets_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ets_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .now_ms_i              (now_ms_i),
    .paused_i              (paused_i),
    .view_class_i          (view_class_i),
    .construction_active_i (construction_active_i),
    .scroll_active_i       (scroll_active_i),
    .scroll_smooth_i       (scroll_smooth_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .ticks_due_o           (ticks_due_o)
  );

endmodule

>>> sv/ets_ctrl.sv
module ets_ctrl
  import ets_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = sts_i.need_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/ets_datapath.sv
module ets_datapath
  import ets_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SPEED_W-1:0]   cfg_wdata_i,
  input  logic [TIME_BITS-1:0] now_ms_i,
  input  logic                 paused_i,
  input  logic [VIEW_W-1:0]    view_class_i,
  input  logic                 construction_active_i,
  input  logic                 scroll_active_i,
  input  logic                 scroll_smooth_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [TICKS_W-1:0]   ticks_due_o
);

  typedef enum logic [1:0] {
    KIND_INVALID,
    KIND_FIRST,
    KIND_DIVIDE
  } kind_e;

  logic [SPEED_W-1:0]   speed_q;
  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] ref_q, ref_d;
  logic [TIME_BITS-1:0] now_q;
  logic [PERIOD_W-1:0]  period_q;
  kind_e                kind_q, kind_d;
  logic [TIME_BITS-1:0] dq_q, dq_d;
  logic [PERIOD_W-1:0]  rem_q, rem_d;
  logic [TICKS_W-1:0]   ticks_q, ticks_d;

  logic [PERIOD_W-1:0]  period;
  logic                 invalid;
  logic [PERIOD_W:0]    trial;
  logic                 fits;

  always_comb begin
    case (view_class_i)
      VIEW_CITY:   period = city_period(speed_q);
      VIEW_EDITOR: period = EDITOR_PERIOD;
      default:     period = '0;
    endcase
    invalid = paused_i || (period == '0) || construction_active_i ||
              (scroll_active_i && !scroll_smooth_i);
    if (invalid)       kind_d = KIND_INVALID;
    else if (!valid_q) kind_d = KIND_FIRST;
    else               kind_d = KIND_DIVIDE;
  end

  assign sts_o.need_div = (kind_d == KIND_DIVIDE);

  // One restoring division step: remainder and quotient shift together.
  assign trial = {rem_q, dq_q[TIME_BITS-1]};
  assign fits  = (trial >= {1'b0, period_q});

  always_comb begin
    dq_d    = dq_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    ref_d   = ref_q;
    ticks_d = ticks_q;
    if (cmd_i.load) begin
      dq_d  = now_ms_i - ref_q;
      rem_d = '0;
    end else if (cmd_i.step) begin
      rem_d = fits ? PERIOD_W'(trial - {1'b0, period_q}) : trial[PERIOD_W-1:0];
      dq_d  = {dq_q[TIME_BITS-2:0], fits};
    end
    if (cmd_i.commit) begin
      case (kind_q)
        KIND_INVALID: begin
          valid_d = 1'b0;
          ticks_d = '0;
        end
        KIND_FIRST: begin
          valid_d = 1'b1;
          ref_d   = now_q;
          ticks_d = TICKS_W'(1);
        end
        KIND_DIVIDE: begin
          valid_d = 1'b1;
          if (dq_q == '0) begin
            ticks_d = '0;
          end else if (dq_q <= TIME_BITS'(MAX_TICKS)) begin
            ticks_d = dq_q[TICKS_W-1:0];
            ref_d   = now_q - TIME_BITS'(rem_q);
          end else begin
            ticks_d = TICKS_W'(MAX_TICKS);
            ref_d   = now_q;
          end
        end
        default: begin
          valid_d = 1'b0;
          ticks_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
      valid_q <= 1'b0;
      ref_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        speed_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
      ref_q   <= ref_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q    <= now_ms_i;
      period_q <= period;
      kind_q   <= kind_d;
    end
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    ticks_q <= ticks_d;
  end

  assign ticks_due_o = ticks_q;

endmodule

>>> verif/elapsed_tick_scheduler_core_tb.sv
`timescale 1ns / 1ps

module elapsed_tick_scheduler_core_tb
  import ets_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 56;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 100;

  localparam logic [VIEW_W-1:0] VIEW_OTHER  = 2'd0;
  localparam logic [VIEW_W-1:0] VIEW_UNUSED = 2'd3;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic                 paused;
    logic [VIEW_W-1:0]    view;
    logic                 building;
    logic                 scrolling;
    logic                 smooth;
  } query_t;

  class tick_scoreboard;
    logic [SPEED_W-1:0]   speed;
    bit                   prior_valid;
    logic [TIME_BITS-1:0] ref_time;
    logic [TICKS_W-1:0]   pending_ticks[$];
    int unsigned          errors;
    logic [PERIOD_W-1:0]  normal_ms[11] = '{702, 502, 352, 242, 162, 112, 82, 57, 37, 22, 16};
    logic [PERIOD_W-1:0]  hyper_ms[6]   = '{702, 16, 8, 5, 3, 2};

    function new();
      speed       = SPEED_RESET;
      prior_valid = 1'b0;
      ref_time    = '0;
      errors      = 0;
    endfunction

    task report_mismatch(input string msg);
      if (errors < MAX_REPORTS) begin
        $display("%0t: mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    function logic [PERIOD_W-1:0] period_for(input logic [VIEW_W-1:0] view);
      int unsigned s;
      if (view == VIEW_EDITOR) return EDITOR_PERIOD;
      if (view != VIEW_CITY) return '0;
      s = (speed > 500) ? 500 : speed;
      if (s < 10) return '0;
      if (s <= 100) return normal_ms[s / 10];
      return hyper_ms[s / 100];
    endfunction

    function void note_query(input query_t q);
      logic [PERIOD_W-1:0]  period;
      logic [TIME_BITS-1:0] span;
      logic [TIME_BITS-1:0] count;
      bit                   was_valid;
      period      = period_for(q.view);
      was_valid   = prior_valid;
      prior_valid = 1'b0;
      if (q.paused || period == '0 || q.building || (q.scrolling && !q.smooth)) begin
        pending_ticks.push_back('0);
        return;
      end
      prior_valid = 1'b1;
      span = q.now_ms - ref_time;
      if (!was_valid) begin
        ref_time = q.now_ms;
        pending_ticks.push_back(TICKS_W'(1));
        return;
      end
      count = span / period;
      if (count == '0) begin
        pending_ticks.push_back('0);
      end else if (count <= MAX_TICKS) begin
        ref_time = q.now_ms - span % period;
        pending_ticks.push_back(count[TICKS_W-1:0]);
      end else begin
        ref_time = q.now_ms;
        pending_ticks.push_back(TICKS_W'(MAX_TICKS));
      end
    endfunction

    task check_result(input logic [TICKS_W-1:0] got);
      logic [TICKS_W-1:0] want;
      if (pending_ticks.size() == 0) begin
        report_mismatch($sformatf("ticks_due %0d with no query outstanding", got));
      end else begin
        want = pending_ticks.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("ticks_due %0d, expected %0d", got, want));
        end
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [SPEED_W-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [TIME_BITS-1:0] now_ms_i = '0;
  logic                 paused_i = 1'b0;
  logic [VIEW_W-1:0]    view_class_i = VIEW_OTHER;
  logic                 construction_active_i = 1'b0;
  logic                 scroll_active_i = 1'b0;
  logic                 scroll_smooth_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [TICKS_W-1:0]   ticks_due_o;

  tick_scoreboard       sb = new();
  int unsigned          tx_idle_pct = 0;
  int unsigned          rx_stall_pct = 0;
  int unsigned          cycle_count = 0;
  logic [TIME_BITS-1:0] clock_ms = '0;

  elapsed_tick_scheduler_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .now_ms_i             (now_ms_i),
    .paused_i             (paused_i),
    .view_class_i         (view_class_i),
    .construction_active_i(construction_active_i),
    .scroll_active_i      (scroll_active_i),
    .scroll_smooth_i      (scroll_smooth_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .ticks_due_o          (ticks_due_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("elapsed_tick_scheduler_core_tb: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(ticks_due_o);
    end
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic query_t make_query(input logic [TIME_BITS-1:0] now_ms,
                                        input logic paused,
                                        input logic [VIEW_W-1:0] view,
                                        input logic building,
                                        input logic scrolling,
                                        input logic smooth);
    query_t q;
    q.now_ms    = now_ms;
    q.paused    = paused;
    q.view      = view;
    q.building  = building;
    q.scrolling = scrolling;
    q.smooth    = smooth;
    return q;
  endfunction

  function automatic query_t random_query();
    query_t              q;
    logic [PERIOD_W-1:0] period;
    int unsigned         pick;
    int unsigned         span;
    if ($urandom_range(99) < 80) begin
      q.paused    = 1'b0;
      q.view      = $urandom_range(1) ? VIEW_EDITOR : VIEW_CITY;
      q.building  = 1'b0;
      q.scrolling = 1'($urandom_range(1));
      q.smooth    = q.scrolling ? 1'b1 : 1'($urandom_range(1));
    end else begin
      q.paused    = 1'($urandom_range(1));
      q.view      = VIEW_W'($urandom_range(3));
      q.building  = 1'($urandom_range(1));
      q.scrolling = 1'($urandom_range(1));
      q.smooth    = 1'($urandom_range(1));
    end
    period = sb.period_for(q.view);
    if (period == '0) period = EDITOR_PERIOD;
    pick = $urandom_range(99);
    if (pick < 55) begin
      span = $urandom_range(period * 23, 0);
    end else if (pick < 70) begin
      span = $urandom_range(period - 1, 0);
    end else if (pick < 85) begin
      span = period * $urandom_range(21, 0) + ($urandom_range(1) ? period - 1 : 0);
    end else begin
      span = $urandom_range(1 << 20, period * 21);
    end
    if (pick < 95) begin
      clock_ms = clock_ms + span;
    end else begin
      clock_ms = $urandom();
    end
    q.now_ms = clock_ms;
    return q;
  endfunction

  task automatic send_query(input query_t q);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i            <= 1'b1;
    now_ms_i              <= q.now_ms;
    paused_i              <= q.paused;
    view_class_i          <= q.view;
    construction_active_i <= q.building;
    scroll_active_i       <= q.scrolling;
    scroll_smooth_i       <= q.smooth;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_query(q);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_ticks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.speed = value;
  endtask

  initial begin
    logic [SPEED_W-1:0] speeds[16];
    speeds = '{0, 9, 10, 19, 55, 99, 100, 101, 199, 250, 333, 499, 500, 501, 777, 1023};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset speed gives a 16 ms city period; the editor view runs at 57 ms.
    send_query(make_query(32'd0, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd15, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd16, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd336, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd677, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd700, 1'b1, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd710, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd720, 1'b0, VIEW_OTHER, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd730, 1'b0, VIEW_UNUSED, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'd740, 1'b0, VIEW_CITY, 1'b1, 1'b0, 1'b0));
    send_query(make_query(32'd750, 1'b0, VIEW_EDITOR, 1'b0, 1'b1, 1'b0));
    send_query(make_query(32'd760, 1'b0, VIEW_EDITOR, 1'b0, 1'b1, 1'b1));
    send_query(make_query(32'd941, 1'b0, VIEW_EDITOR, 1'b0, 1'b0, 1'b1));
    send_query(make_query(32'hFFFF_FFF0, 1'b0, VIEW_EDITOR, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'h0000_0060, 1'b0, VIEW_EDITOR, 1'b0, 1'b0, 1'b0));
    send_query(make_query(32'hFFFF_FFFF, 1'b1, VIEW_UNUSED, 1'b1, 1'b1, 1'b1));
    send_query(make_query(32'hFFFF_FFFF, 1'b0, VIEW_CITY, 1'b0, 1'b1, 1'b1));
    send_query(make_query(32'h0000_0000, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b1));
    send_query(make_query(32'h0000_0140, 1'b0, VIEW_CITY, 1'b0, 1'b0, 1'b0));
    drain_results();

    for (int phase = 0; phase < 16; phase++) begin
      if (phase < 5) begin
        tx_idle_pct  = 10;
        rx_stall_pct = 74;
      end else if (phase < 10) begin
        tx_idle_pct  = 74;
        rx_stall_pct = 10;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      write_speed(speeds[phase]);
      clock_ms = $urandom_range(1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(30000);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_query(random_query());
      end
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("elapsed_tick_scheduler_core_tb: clean");
    end else begin
      $display("elapsed_tick_scheduler_core_tb: errors");
    end
    $finish;
  end

endmodule
